// File: rtl/core/selq_pkg.sv
// Shared types and codes of the shared/exclusive lock queue unit.
// No dependencies; used by the top level through scoped names.
`timescale 1ns / 1ps
`default_nettype none
package selq_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] MODE_LOCK      = 2'd0;
    localparam logic [1:0] MODE_UNLOCK    = 2'd1;
    localparam logic [1:0] MODE_UPGRADE   = 2'd2;
    localparam logic [1:0] MODE_DOWNGRADE = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ABSENT   = 2'd1;
    localparam logic [1:0] STAT_TBL_FULL = 2'd2;
    localparam logic [1:0] STAT_Q_FULL   = 2'd3;

    localparam int NAME_HI_W = 16;
    localparam int NAME_LO_W = 64;
    localparam int TXN_W     = 31;

    // One queue entry as stored in the queue memory.
    typedef struct packed {
        logic [TXN_W-1:0] txn;
        logic             excl;
        logic             waiting;
    } entry_t;

endpackage
`default_nettype wire

// File: rtl/core/shared_exclusive_lock_queue_unit.sv
// Shared/exclusive lock manager: tag search, queue load, update, write back, dump.
// Depends on selq_pkg and selq_ram.
// Flow: tag search over the used slots through the slot memory read port,
// then on a miss a new slot for a lock; queue load through the queue memory
// read port; update; write back of the queue and slot entry; dump of
// max(N,1) output beats, N = queue length.
// One operation at a time: a new request is taken only when idle, after the
// dump of the last one has been issued.
// Reset (aresetn low, synchronous): clears the slot fill count, control
// state and output valid; memory contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none
module shared_exclusive_lock_queue_unit #(
    parameter int RESOURCE_SLOTS = 16,
    parameter int QUEUE_DEPTH    = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: resource_name_hi[15:0], resource_name_lo[79:16], txn_id[110:80],
    //        lock_exclusive[111]
    input  wire logic [111:0] s_tdata,
    // tuser: mode[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: status[1:0], entry_valid[2], entry_txn[33:3],
    //        entry_is_exclusive[34], entry_is_waiting[35], zero fill[39:36]
    output logic [39:0]       m_tdata,
    output logic              m_tlast
);

    localparam int SW    = $clog2(RESOURCE_SLOTS);
    localparam int CW    = $clog2(RESOURCE_SLOTS + 1);
    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int NW    = $clog2(QUEUE_DEPTH + 1);
    localparam int QROWS = RESOURCE_SLOTS * (2 ** QW);
    localparam int HW    = selq_pkg::NAME_HI_W;
    localparam int LW    = selq_pkg::NAME_LO_W;
    localparam int TW    = selq_pkg::TXN_W;
    localparam int SRW   = NW + HW + LW;
    localparam int EW    = $bits(selq_pkg::entry_t);

    typedef selq_pkg::entry_t qarr_t [QUEUE_DEPTH];

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_SRD   = 10'b00_0000_0010,
        ST_SCMP  = 10'b00_0000_0100,
        ST_MISS  = 10'b00_0000_1000,
        ST_LOAD  = 10'b00_0001_0000,
        ST_EXEC  = 10'b00_0010_0000,
        ST_GRANT = 10'b00_0100_0000,
        ST_USCAN = 10'b00_1000_0000,
        ST_DSUB  = 10'b01_0000_0000,
        ST_WB    = 10'b10_0000_0000
    } exec_state_t;

    typedef enum logic [1:0] {
        PH_WORK = 2'b01,
        PH_DUMP = 2'b10
    } phase_t;

    // Take entry r out, move entries 0..r-1 back by one and put v at the front.
    function automatic qarr_t rot_front(qarr_t q, logic [NW-1:0] r, selq_pkg::entry_t v);
        qarr_t o;
        o[0] = v;
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
            o[k] = (NW'(k) <= r) ? q[k-1] : q[k];
        end
        return o;
    endfunction

    // Remove entry r, close the gap.
    function automatic qarr_t drop_at(qarr_t q, logic [NW-1:0] r);
        qarr_t o;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            o[k] = (NW'(k) >= r && k + 1 < QUEUE_DEPTH) ? q[k+1] : q[k];
        end
        return o;
    endfunction

    exec_state_t      state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       mode_reg, mode_next;
    logic [HW-1:0]    hi_reg, hi_next;
    logic [LW-1:0]    lo_reg, lo_next;
    logic [TW-1:0]    txn_reg, txn_next;
    logic             lx_reg, lx_next;
    logic [1:0]       status_reg, status_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [NW-1:0]    i_reg, i_next;
    logic [NW-1:0]    j_reg, j_next;
    logic [NW-1:0]    k_reg, k_next;
    logic             cap_vld_reg, cap_vld_next;
    logic [QW-1:0]    cap_idx_reg, cap_idx_next;
    qarr_t            q_reg, q_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [39:0]      m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    logic             sram_we;
    logic [SW-1:0]    sram_raddr;
    logic [SRW-1:0]   sram_wdata, sram_rdata;
    logic             qram_we;
    logic [SW+QW-1:0] qram_waddr, qram_raddr;
    logic [EW-1:0]    qram_wdata, qram_rdata;

    // Slot table: {queue length, name hi, name lo} per slot.
    selq_ram #(.WIDTH(SRW), .DEPTH(RESOURCE_SLOTS)) u_slot_ram (
        .aclk  (aclk),
        .we    (sram_we),
        .waddr (slot_reg),
        .wdata (sram_wdata),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // Queue entries: row {slot, position}.
    selq_ram #(.WIDTH(EW), .DEPTH(QROWS)) u_queue_ram (
        .aclk  (aclk),
        .we    (qram_we),
        .waddr (qram_waddr),
        .wdata (qram_wdata),
        .raddr (qram_raddr),
        .rdata (qram_rdata)
    );

    assign s_tready = (phase_reg == PH_WORK) && (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    selq_pkg::entry_t e_cur, e_j, e_new, e_mod;
    logic [NW-1:0]    ip1;
    logic             sole, in_place, name_hit;

    always_comb begin
        e_cur = q_reg[i_reg[QW-1:0]];
        e_j   = q_reg[j_reg[QW-1:0]];
        ip1   = i_reg + NW'(1);
        // Sole holder: no other granted entry in the queue.
        sole  = 1'b1;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (NW'(k) < n_reg && NW'(k) != i_reg && !q_reg[k].waiting) begin
                sole = 1'b0;
            end
        end
        in_place = !e_cur.waiting &&
                   (sole || (ip1 < n_reg && q_reg[ip1[QW-1:0]].excl));
        name_hit = (sram_rdata[HW+LW-1:LW] == hi_reg) && (sram_rdata[LW-1:0] == lo_reg);
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        txn_next      = txn_reg;
        lx_next       = lx_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        cap_vld_next  = 1'b0;
        cap_idx_next  = cap_idx_reg;
        q_next        = q_reg;
        e_new         = '{txn: txn_reg, excl: lx_reg, waiting: 1'b0};
        e_mod         = e_cur;
        sram_we       = 1'b0;
        sram_raddr    = idx_reg[SW-1:0];
        sram_wdata    = {n_reg, hi_reg, lo_reg};
        qram_we       = 1'b0;
        qram_raddr    = {slot_reg, k_reg[QW-1:0]};
        qram_waddr    = {slot_reg, k_reg[QW-1:0]};
        qram_wdata    = q_reg[k_reg[QW-1:0]];
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (phase_reg == PH_DUMP) begin
            // Emit one beat per queue entry, or one empty beat.
            if (!m_tvalid_reg || m_tready) begin
                m_tvalid_next = 1'b1;
                if (n_reg == '0) begin
                    m_tdata_next = {37'd0, 1'b0, status_reg};
                    m_tlast_next = 1'b1;
                    phase_next   = PH_WORK;
                end else begin
                    m_tdata_next = {4'd0, q_reg[k_reg[QW-1:0]].waiting,
                                    q_reg[k_reg[QW-1:0]].excl,
                                    q_reg[k_reg[QW-1:0]].txn, 1'b1, status_reg};
                    m_tlast_next = (k_reg + NW'(1) == n_reg);
                    k_next       = k_reg + NW'(1);
                    if (k_reg + NW'(1) == n_reg) begin
                        phase_next = PH_WORK;
                    end
                end
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mode_next   = s_tuser;
                        hi_next     = s_tdata[15:0];
                        lo_next     = s_tdata[79:16];
                        txn_next    = s_tdata[110:80];
                        lx_next     = s_tdata[111];
                        status_next = selq_pkg::STAT_OK;
                        idx_next    = '0;
                        n_next      = '0;
                        k_next      = '0;
                        state_next  = (cnt_reg == '0) ? ST_MISS : ST_SRD;
                    end
                end
                ST_SRD: begin
                    state_next = ST_SCMP;
                end
                ST_SCMP: begin
                    if (name_hit) begin
                        slot_next  = idx_reg[SW-1:0];
                        n_next     = sram_rdata[SRW-1:HW+LW];
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end else if (idx_reg + CW'(1) >= cnt_reg) begin
                        state_next = ST_MISS;
                    end else begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_SRD;
                    end
                end
                ST_MISS: begin
                    // Slots fill in order and never free, so used slots are 0..cnt-1.
                    if (mode_reg == selq_pkg::MODE_LOCK && cnt_reg < CW'(RESOURCE_SLOTS)) begin
                        slot_next  = cnt_reg[SW-1:0];
                        cnt_next   = cnt_reg + CW'(1);
                        i_next     = '0;
                        state_next = ST_EXEC;
                    end else begin
                        status_next = (mode_reg == selq_pkg::MODE_LOCK) ?
                                      selq_pkg::STAT_TBL_FULL : selq_pkg::STAT_ABSENT;
                        state_next  = ST_IDLE;
                        phase_next  = PH_DUMP;
                    end
                end
                ST_LOAD: begin
                    // Issue one read per cycle, capture it in the cycle after.
                    if (cap_vld_reg) begin
                        q_next[cap_idx_reg] = selq_pkg::entry_t'(qram_rdata);
                    end
                    if (k_reg < n_reg) begin
                        cap_vld_next = 1'b1;
                        cap_idx_next = k_reg[QW-1:0];
                        k_next       = k_reg + NW'(1);
                    end else if (!cap_vld_reg) begin
                        i_next     = '0;
                        state_next = ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    unique case (mode_reg)
                        selq_pkg::MODE_LOCK: begin
                            k_next     = '0;
                            state_next = ST_WB;
                            if (n_reg == '0) begin
                                q_next[0] = e_new;
                                n_next    = NW'(1);
                            end else if (n_reg >= NW'(QUEUE_DEPTH)) begin
                                status_next = selq_pkg::STAT_Q_FULL;
                            end else if (!q_reg[0].excl && !lx_reg) begin
                                q_next = rot_front(q_reg, n_reg, e_new);
                                n_next = n_reg + NW'(1);
                            end else begin
                                e_new.waiting            = 1'b1;
                                q_next[n_reg[QW-1:0]]    = e_new;
                                n_next                   = n_reg + NW'(1);
                            end
                        end
                        selq_pkg::MODE_UNLOCK: begin
                            // Find the first entry of the transaction, drop it.
                            if (i_reg >= n_reg) begin
                                state_next = ST_GRANT;
                            end else if (e_cur.txn == txn_reg) begin
                                q_next     = drop_at(q_reg, i_reg);
                                n_next     = n_reg - NW'(1);
                                state_next = ST_GRANT;
                            end else begin
                                i_next = i_reg + NW'(1);
                            end
                        end
                        selq_pkg::MODE_UPGRADE: begin
                            if (i_reg >= n_reg) begin
                                k_next     = '0;
                                state_next = ST_WB;
                            end else if (e_cur.txn == txn_reg && !e_cur.excl) begin
                                if (in_place) begin
                                    q_next[i_reg[QW-1:0]].excl = 1'b1;
                                    i_next = ip1;
                                end else begin
                                    // Requeue as exclusive waiting at the back; hold i.
                                    e_mod.excl    = 1'b1;
                                    e_mod.waiting = 1'b1;
                                    q_next = drop_at(q_reg, i_reg);
                                    q_next[QW'(n_reg - NW'(1))] = e_mod;
                                end
                            end else begin
                                i_next = ip1;
                            end
                        end
                        selq_pkg::MODE_DOWNGRADE: begin
                            if (i_reg >= n_reg) begin
                                k_next     = '0;
                                state_next = ST_WB;
                            end else if (e_cur.txn == txn_reg && e_cur.excl) begin
                                if (!e_cur.waiting) begin
                                    q_next[i_reg[QW-1:0]].excl = 1'b0;
                                    j_next     = ip1;
                                    state_next = ST_DSUB;
                                end else if (!q_reg[0].excl && !q_reg[0].waiting) begin
                                    e_mod.excl    = 1'b0;
                                    e_mod.waiting = 1'b0;
                                    q_next = rot_front(q_reg, i_reg, e_mod);
                                    i_next = ip1;
                                end else if (q_reg[0].excl && !q_reg[0].waiting) begin
                                    q_next[i_reg[QW-1:0]].excl = 1'b0;
                                    i_next = ip1;
                                end else begin
                                    i_next = ip1;
                                end
                            end else begin
                                i_next = ip1;
                            end
                        end
                        default: begin
                            state_next = ST_WB;
                        end
                    endcase
                end
                ST_GRANT: begin
                    k_next = '0;
                    if (n_reg == '0 || !q_reg[0].waiting) begin
                        state_next = ST_WB;
                    end else if (q_reg[0].excl) begin
                        q_next[0].waiting = 1'b0;
                        state_next = ST_WB;
                    end else begin
                        i_next     = '0;
                        state_next = ST_USCAN;
                    end
                end
                ST_USCAN: begin
                    // Grant every waiting shared entry, stacking them at the front.
                    if (i_reg >= n_reg) begin
                        k_next     = '0;
                        state_next = ST_WB;
                    end else begin
                        if (e_cur.waiting && !e_cur.excl) begin
                            e_mod.waiting = 1'b0;
                            q_next = rot_front(q_reg, i_reg, e_mod);
                        end
                        i_next = ip1;
                    end
                end
                ST_DSUB: begin
                    // Pull shared entries behind the downgraded one to the front.
                    if (j_reg >= n_reg) begin
                        i_next     = ip1;
                        state_next = ST_EXEC;
                    end else begin
                        if (!e_j.excl) begin
                            e_mod         = e_j;
                            e_mod.waiting = 1'b0;
                            q_next = rot_front(q_reg, j_reg, e_mod);
                            i_next = ip1;
                        end
                        j_next = j_reg + NW'(1);
                    end
                end
                ST_WB: begin
                    sram_we = (k_reg == '0);
                    if (k_reg < n_reg) begin
                        qram_we = 1'b1;
                        k_next  = k_reg + NW'(1);
                    end else begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                        phase_next = PH_DUMP;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_WORK;
            cnt_reg      <= '0;
            cap_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            cap_vld_reg  <= cap_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        txn_reg     <= txn_next;
        lx_reg      <= lx_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        cap_idx_reg <= cap_idx_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (n_reg <= NW'(QUEUE_DEPTH)))
        else $error("queue length beyond depth");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(RESOURCE_SLOTS))
        else $error("slot fill count beyond table size");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_USCAN || state_reg == ST_DSUB) |-> (i_reg <= n_reg))
        else $error("scan index beyond queue length");

    a_no_accept_in_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DUMP) |-> !s_tready)
        else $error("input taken while dumping");

endmodule
`default_nettype wire

// File: rtl/core/selq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module selq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
